// ----- rtl/wbps_pkg.sv -----
// Package for the wildcard byte pattern scanner.
// Holds register indexes, fixed widths and the structs shared between modules.
// No dependencies.
package wbps_pkg;

	// Fixed signature storage: three 64-bit words of eight bytes each.
	localparam int SIG_BYTES      = 24;
	localparam int LEN_BITS       = 7;
	localparam int LEN_REG_BITS   = 5;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 64;
	localparam int RES_OFF_BITS   = 32;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_SIG_LENGTH = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SIG_LOW    = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SIG_MID    = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SIG_HIGH   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WILD_MASK  = 3'd4;

	// Signature setup as seen by the match logic.
	typedef struct packed {
		logic [SIG_BYTES-1:0][7:0] sig_bytes;
		logic [SIG_BYTES-1:0]      wild;
		logic [LEN_REG_BITS-1:0]   length;
	} sig_cfg_t;

	// Outcome of one processed beat.
	typedef struct packed {
		logic                    emit;
		logic                    found;
		logic [RES_OFF_BITS-1:0] offset;
	} scan_res_t;

endpackage

// ----- rtl/wbps_region_if.sv -----
// Valid/ready channel for region bytes entering the scanner.
// Depends on nothing.
interface wbps_region_if;
	logic       valid;
	logic       ready;
	logic [7:0] region_byte;
	logic       region_end;

	modport source (output valid, output region_byte, output region_end, input ready);
	modport sink (input valid, input region_byte, input region_end, output ready);
endinterface

// ----- rtl/wbps_result_if.sv -----
// Valid/ready channel for scan results leaving the scanner.
// Depends on nothing.
interface wbps_result_if;
	logic        valid;
	logic        ready;
	logic        match_found;
	logic [31:0] match_offset;

	modport source (output valid, output match_found, output match_offset, input ready);
	modport sink (input valid, input match_found, input match_offset, output ready);
endinterface

// ----- rtl/wbps_cfg_regs.sv -----
// Configuration register file of the wildcard byte pattern scanner.
// Depends on wbps_pkg.
module wbps_cfg_regs
	import wbps_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [CFG_INDEX_BITS-1:0] wr_index,
	input  logic [CFG_DATA_BITS-1:0]  wr_data,
	output sig_cfg_t                  cfg
);

	logic [LEN_REG_BITS-1:0]  length_q;
	logic [CFG_DATA_BITS-1:0] sig_low_q;
	logic [CFG_DATA_BITS-1:0] sig_mid_q;
	logic [CFG_DATA_BITS-1:0] sig_high_q;
	logic [SIG_BYTES-1:0]     wild_q;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q   <= LEN_REG_BITS'(1);
			sig_low_q  <= '0;
			sig_mid_q  <= '0;
			sig_high_q <= '0;
			wild_q     <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SIG_LENGTH: length_q   <= wr_data[LEN_REG_BITS-1:0];
				REG_SIG_LOW:    sig_low_q  <= wr_data;
				REG_SIG_MID:    sig_mid_q  <= wr_data;
				REG_SIG_HIGH:   sig_high_q <= wr_data;
				REG_WILD_MASK:  wild_q     <= wr_data[SIG_BYTES-1:0];
				default: ;
			endcase
		end
	end

	// Byte 0 sits in the low bits of the low word.
	assign cfg.sig_bytes = {sig_high_q, sig_mid_q, sig_low_q};
	assign cfg.wild      = wild_q;
	assign cfg.length    = length_q;

endmodule

// ----- rtl/wbps_window.sv -----
// Byte window, region byte counter and masked signature compare.
// Depends on wbps_pkg; driven by the input stage of the top level.
module wbps_window
	import wbps_pkg::*;
#(
	parameter int MAX_SIGNATURE_BYTES = 24,
	parameter int OFFSET_BITS         = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      beat,
	input  logic [7:0] region_byte,
	input  logic      region_end,
	input  sig_cfg_t  cfg,
	output scan_res_t res
);

	localparam int IW        = (MAX_SIGNATURE_BYTES > 1) ? $clog2(MAX_SIGNATURE_BYTES) : 1;
	localparam int SIG_DEPTH = 2 ** IW;

	logic [7:0]             window_q [MAX_SIGNATURE_BYTES];
	logic [OFFSET_BITS-1:0] count_q;
	logic                   match_rep_q;

	logic [7:0]             win_new [MAX_SIGNATURE_BYTES];
	logic [7:0]             sig_arr [SIG_DEPTH];
	logic                   wild_arr [SIG_DEPTH];
	logic [MAX_SIGNATURE_BYTES-1:0] pos_ok;
	logic [LEN_BITS-1:0]    len_raw;
	logic [LEN_BITS-1:0]    len;
	logic [OFFSET_BITS-1:0] count_next;
	logic [OFFSET_BITS-1:0] offset_full;
	logic [RES_OFF_BITS-1:0] offset_low;
	logic                   hit;

	// Window as it stands once the current byte is shifted in; entry 0 is newest.
	assign win_new[0] = region_byte;
	for (genvar j = 1; j < MAX_SIGNATURE_BYTES; j++) begin : g_win
		assign win_new[j] = window_q[j-1];
	end

	// Signature bytes past the stored ones are zero and never wildcards.
	for (genvar k = 0; k < SIG_DEPTH; k++) begin : g_sig
		if (k < SIG_BYTES) begin : g_real
			assign sig_arr[k]  = cfg.sig_bytes[k];
			assign wild_arr[k] = cfg.wild[k];
		end else begin : g_pad
			assign sig_arr[k]  = 8'h00;
			assign wild_arr[k] = 1'b0;
		end
	end

	// Active length: zero reads as one, too long clamps to the window depth.
	always_comb begin
		len_raw = LEN_BITS'(cfg.length);
		if (len_raw == '0)
			len = LEN_BITS'(1);
		else if (len_raw > LEN_BITS'(MAX_SIGNATURE_BYTES))
			len = LEN_BITS'(MAX_SIGNATURE_BYTES);
		else
			len = len_raw;
	end

	// Window entry j lines up with signature byte len-1-j.
	for (genvar j = 0; j < MAX_SIGNATURE_BYTES; j++) begin : g_cmp
		logic                in_use;
		logic [LEN_BITS-1:0] idx;
		assign in_use    = LEN_BITS'(j) < len;
		assign idx       = len - LEN_BITS'(1) - LEN_BITS'(j);
		assign pos_ok[j] = !in_use || wild_arr[idx[IW-1:0]]
			|| (win_new[j] == sig_arr[idx[IW-1:0]]);
	end

	// Saturating byte count and the offset of the first matching byte.
	assign count_next  = (&count_q) ? count_q : count_q + OFFSET_BITS'(1);
	assign hit         = (&pos_ok) && (count_next >= OFFSET_BITS'(len));
	assign offset_full = count_next - OFFSET_BITS'(len);

	if (OFFSET_BITS >= RES_OFF_BITS) begin : g_off_trunc
		assign offset_low = offset_full[RES_OFF_BITS-1:0];
	end else begin : g_off_ext
		assign offset_low = RES_OFF_BITS'(offset_full);
	end

	// Result of this beat: a match, or a region end without one.
	always_comb begin
		res.emit   = beat && !match_rep_q && (hit || region_end);
		res.found  = hit;
		res.offset = hit ? offset_low : '0;
	end

	// Shift the window only while the region is still being searched.
	always_ff @(posedge clk) begin
		if (beat && !match_rep_q) begin
			for (int j = 0; j < MAX_SIGNATURE_BYTES; j++)
				window_q[j] <= win_new[j];
		end
	end

	// Count and match flag; the end mark re-arms for the next region.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			match_rep_q <= 1'b0;
		end else if (beat) begin
			if (region_end) begin
				count_q     <= '0;
				match_rep_q <= 1'b0;
			end else if (!match_rep_q) begin
				count_q     <= count_next;
				match_rep_q <= hit;
			end
		end
	end

endmodule

// ----- rtl/wildcard_byte_pattern_scan.sv -----
// Wildcard byte pattern scanner, top level.
// A byte is accepted into the input register; its result then loads into the result register.
// Throughput: one byte per cycle if results are taken; compare and next count are combinational.
// A waiting result stalls the input register only; one more byte is still taken.
// Reset (arst_n low) resets the count, the match flag, both valid flags and the config registers.
// Depends on wbps_pkg, wbps_region_if, wbps_result_if, wbps_cfg_regs and wbps_window.
module wildcard_byte_pattern_scan
	import wbps_pkg::*;
#(
	parameter int MAX_SIGNATURE_BYTES = 24,
	parameter int OFFSET_BITS         = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [CFG_INDEX_BITS-1:0] wr_index,
	input  logic [CFG_DATA_BITS-1:0]  wr_data,
	wbps_region_if.sink               region,
	wbps_result_if.source             result
);

	sig_cfg_t  cfg;
	scan_res_t res;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        advance;
	logic        res_valid_q;
	logic        res_found_q;
	logic [31:0] res_offset_q;

	wbps_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// The input beat moves on when the result register is free or being emptied.
	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign region.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (region.ready) begin
			valid_s1 <= region.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (region.ready && region.valid) begin
			byte_s1 <= region.region_byte;
			end_s1  <= region.region_end;
		end
	end

	wbps_window #(
		.MAX_SIGNATURE_BYTES (MAX_SIGNATURE_BYTES),
		.OFFSET_BITS         (OFFSET_BITS)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.beat        (advance),
		.region_byte (byte_s1),
		.region_end  (end_s1),
		.cfg         (cfg),
		.res         (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res.emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.emit) begin
			res_found_q  <= res.found;
			res_offset_q <= res.offset;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.match_found  = res_found_q;
	assign result.match_offset = res_offset_q;

	// A result is only produced when the result register can take it.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit |-> (!res_valid_q || result.ready))
		else $error("result produced while result register still full");

	// A produced result is on the output in the next cycle.
	a_emit_shown: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit |=> (res_valid_q && (res_found_q == $past(res.found))))
		else $error("produced result not loaded into result register");

	// A region that ends without a match reports a zero offset.
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_found_q) |-> (res_offset_q == 32'd0))
		else $error("not-found result carries a nonzero offset");

endmodule
